// ----- rtl/i2cm_pkg.sv -----
// shared types, command codes and sequence lengths for the i2c master bit engine
// no dependencies; used by i2cm_step, i2c_master_bit_engine, i2cm_bus_checker and the testbench
`default_nettype none

package i2cm_pkg;

   localparam int unsigned CmdWidth   = 3;
   localparam int unsigned StepWidth  = 5;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned ReqDataW   = 16;
   localparam int unsigned ReqUserW   = 4;
   localparam int unsigned RspDataW   = 16;
   localparam int unsigned BitsPerByte = 8;

   typedef enum logic [CmdWidth-1:0] {
      CMD_START = 3'd0,
      CMD_STOP  = 3'd1,
      CMD_WRITE = 3'd2,
      CMD_READ  = 3'd3,
      CMD_SACK  = 3'd4,
      CMD_RACK  = 3'd5
   } cmd_type;

   localparam logic [ByteWidth-1:0] MsbMask = 8'h80;

   // one input tick, decoded from the stream beat
   typedef struct packed {
      logic                 cmd_valid;
      logic [CmdWidth-1:0]  mode;
      logic [ByteWidth-1:0] tx_byte;
      logic                 ack_value;
      logic                 sda_in;
   } i2cm_req_type;

   // sequencer state carried from tick to tick
   typedef struct packed {
      cmd_type               active_command;
      logic [StepWidth-1:0]  step_count;
      logic [ByteWidth-1:0]  shift_reg;
      logic                  running;
      logic                  scl_level;
      logic                  sda_level;
      logic                  ack_seen;
      logic [ByteWidth-1:0]  rx_latch;
   } i2cm_state_type;

   // one result tick
   typedef struct packed {
      logic                 scl;
      logic                 sda_release;
      logic                 busy_res;
      logic                 done_res;
      logic [ByteWidth-1:0] rx_byte;
      logic                 rx_ack;
   } i2cm_rsp_type;

   localparam i2cm_state_type StateReset = '{
      active_command: CMD_START,
      step_count:     '0,
      shift_reg:      '0,
      running:        1'b0,
      scl_level:      1'b1,
      sda_level:      1'b1,
      ack_seen:       1'b0,
      rx_latch:       '0
   };

   // number of pin steps in each sequence
   function automatic logic [StepWidth-1:0] seq_len(input cmd_type cmd);
      logic [StepWidth-1:0] len;
      case (cmd)
         CMD_START: len = 5'd4;
         CMD_STOP:  len = 5'd3;
         CMD_WRITE: len = 5'd24;
         CMD_READ:  len = 5'd17;
         CMD_SACK:  len = 5'd3;
         CMD_RACK:  len = 5'd3;
         default:   len = 5'd3;
      endcase
      return len;
   endfunction

   // bit index of a write step: step / 3, by threshold compares
   function automatic logic [2:0] write_bit(input logic [StepWidth-1:0] s);
      logic [2:0] idx;
      idx = 3'd0;
      for (int i = 1; i < BitsPerByte; i++) begin
         if (s >= StepWidth'(3 * i)) begin
            idx = 3'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/i2c_master_bit_engine.sv -----
// top level of the i2c master bit engine: input register, step logic, result register
// depends on i2cm_pkg and i2cm_step
//
//   channel | direction | payload
//   req     | in        | tuser: cmd_valid, mode; tdata: tx_byte, ack_value, sda_in
//   rsp     | out       | tdata: scl, sda_release, busy_res, done_res, rx_byte, rx_ack
//
// one beat in gives one beat out; a beat can be taken every cycle while the result side is not stalled
// a beat passes the input register, then the step logic into the result register
// the sequencer state moves only when a beat goes from the input to the result register
// a stalled result holds the result register and then the input register; nothing is dropped
// synchronous active-high reset: pins released high, sequencer idle, both registers empty
`default_nettype none

module i2c_master_bit_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [i2cm_pkg::ReqDataW-1:0] req_tdata,  // tx_byte[7:0], ack_value, sda_in, zeros
   input  wire logic [i2cm_pkg::ReqUserW-1:0] req_tuser,  // cmd_valid, mode[2:0]
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   output      logic [i2cm_pkg::RspDataW-1:0] rsp_tdata   // scl, sda_release, busy_res,
                                                          // done_res, rx_byte[7:0], rx_ack, zeros
);

   // input register
   logic                   in_valid_ff;
   logic                   in_valid_in;
   i2cm_pkg::i2cm_req_type in_req_ff;
   i2cm_pkg::i2cm_req_type in_req_in;

   // sequencer state
   i2cm_pkg::i2cm_state_type state_ff;
   i2cm_pkg::i2cm_state_type state_in;
   i2cm_pkg::i2cm_state_type state_step;

   // result register
   logic                   out_valid_ff;
   logic                   out_valid_in;
   i2cm_pkg::i2cm_rsp_type out_rsp_ff;
   i2cm_pkg::i2cm_rsp_type out_rsp_in;
   i2cm_pkg::i2cm_rsp_type rsp_step;

   logic advance;

   // a beat moves on when the result register is empty or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   i2cm_step u_step (
      .state_cur (state_ff),
      .req       (in_req_ff),
      .state_nxt (state_step),
      .rsp       (rsp_step)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_req_in   = in_req_ff;
      if (req_tready) begin
         in_valid_in         = req_tvalid;
         in_req_in.cmd_valid = req_tuser[0];
         in_req_in.mode      = req_tuser[3:1];
         in_req_in.tx_byte   = req_tdata[7:0];
         in_req_in.ack_value = req_tdata[8];
         in_req_in.sda_in    = req_tdata[9];
      end

      state_in     = advance ? state_step : state_ff;
      out_rsp_in   = advance ? rsp_step : out_rsp_ff;
      out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= i2cm_pkg::StateReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      // payload, no reset needed
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000,
                        out_rsp_ff.rx_ack,
                        out_rsp_ff.rx_byte,
                        out_rsp_ff.done_res,
                        out_rsp_ff.busy_res,
                        out_rsp_ff.sda_release,
                        out_rsp_ff.scl};

`ifndef SYNTHESIS
   // a running sequence never sits past its last step
   assert property (@(posedge clock) disable iff (reset)
      state_ff.running |-> (state_ff.step_count < i2cm_pkg::seq_len(state_ff.active_command)))
      else $error("step count beyond sequence length");

   // a finishing beat is never also busy
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_rsp_ff.done_res && out_rsp_ff.busy_res))
      else $error("done and busy together");

   // a held input beat is not lost while the result side stalls
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_req_ff)))
      else $error("held input beat lost");

   // state only changes when a beat moves into the result register
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state moved without a beat");

   // an idle tick without a command leaves the pins alone
   assert property (@(posedge clock) disable iff (reset)
      (advance && !state_ff.running && !in_req_ff.cmd_valid)
         |=> ($stable(state_ff.scl_level) && $stable(state_ff.sda_level)))
      else $error("pins moved on idle tick");
`endif

endmodule

`default_nettype wire

// ----- rtl/i2cm_step.sv -----
// one pin step of the i2c master sequencer: accept a command, advance the sequence
// depends on i2cm_pkg
`default_nettype none

module i2cm_step (
   input  var i2cm_pkg::i2cm_state_type state_cur,
   input  var i2cm_pkg::i2cm_req_type   req,
   output i2cm_pkg::i2cm_state_type     state_nxt,
   output i2cm_pkg::i2cm_rsp_type       rsp
);

   i2cm_pkg::i2cm_state_type st;
   i2cm_pkg::i2cm_state_type sn;
   logic [i2cm_pkg::StepWidth-1:0] s;
   logic [i2cm_pkg::StepWidth-1:0] step_inc;
   logic [2:0] bit_idx;
   logic [i2cm_pkg::StepWidth-1:0] phase;
   logic done;

   always_comb begin
      st = state_cur;
      // idle block takes a known command
      if (!st.running && req.cmd_valid && (req.mode <= i2cm_pkg::CMD_RACK)) begin
         st.active_command = i2cm_pkg::cmd_type'(req.mode);
         st.step_count     = '0;
         st.running        = 1'b1;
         if (req.mode == i2cm_pkg::CMD_WRITE) begin
            st.shift_reg = req.tx_byte;
         end else if (req.mode == i2cm_pkg::CMD_SACK) begin
            st.shift_reg = {{(i2cm_pkg::ByteWidth-1){1'b0}}, req.ack_value};
         end
      end

      s        = st.step_count;
      bit_idx  = i2cm_pkg::write_bit(s);
      phase    = s - i2cm_pkg::StepWidth'(3 * bit_idx);
      sn       = st;
      done     = 1'b0;
      step_inc = s + 5'd1;

      if (st.running) begin
         case (st.active_command)
            i2cm_pkg::CMD_START: begin
               if (s == 5'd0)      sn.sda_level = 1'b1;
               else if (s == 5'd1) sn.scl_level = 1'b1;
               else if (s == 5'd2) sn.sda_level = 1'b0;
               else                sn.scl_level = 1'b0;
            end
            i2cm_pkg::CMD_STOP: begin
               if (s == 5'd0)      sn.sda_level = 1'b0;
               else if (s == 5'd1) sn.scl_level = 1'b1;
               else                sn.sda_level = 1'b1;
            end
            i2cm_pkg::CMD_WRITE: begin
               if (phase == 5'd0) begin
                  sn.sda_level = |(st.shift_reg & (i2cm_pkg::MsbMask >> bit_idx));
               end else if (phase == 5'd1) begin
                  sn.scl_level = 1'b1;
               end else begin
                  sn.scl_level = 1'b0;
               end
            end
            i2cm_pkg::CMD_READ: begin
               if (s == 5'd0) begin
                  sn.sda_level = 1'b1;
                  sn.shift_reg = '0;
               end else if (s[0]) begin
                  sn.scl_level = 1'b1;
               end else begin
                  sn.shift_reg = {st.shift_reg[i2cm_pkg::ByteWidth-2:0], req.sda_in};
                  sn.scl_level = 1'b0;
               end
            end
            i2cm_pkg::CMD_SACK: begin
               if (s == 5'd0)      sn.sda_level = st.shift_reg[0];
               else if (s == 5'd1) sn.scl_level = 1'b1;
               else                sn.scl_level = 1'b0;
            end
            default: begin
               // read ack
               if (s == 5'd0)      sn.sda_level = 1'b1;
               else if (s == 5'd1) sn.scl_level = 1'b1;
               else begin
                  sn.ack_seen  = req.sda_in;
                  sn.scl_level = 1'b0;
               end
            end
         endcase
         sn.step_count = step_inc;
         if (step_inc >= i2cm_pkg::seq_len(st.active_command)) begin
            sn.running = 1'b0;
            done       = 1'b1;
            if (st.active_command == i2cm_pkg::CMD_READ) begin
               sn.rx_latch = sn.shift_reg;
            end
         end
      end
   end

   assign state_nxt       = sn;
   assign rsp.scl         = sn.scl_level;
   assign rsp.sda_release = sn.sda_level;
   assign rsp.busy_res    = sn.running;
   assign rsp.done_res    = done;
   assign rsp.rx_byte     = sn.rx_latch;
   assign rsp.rx_ack      = sn.ack_seen;

endmodule

`default_nettype wire

// ----- test/i2cm_bus_checker.sv -----
// checker for the i2c master bit engine: follows both stream channels, predicts each result beat
// depends on i2cm_pkg for the command codes and the result record
`timescale 1ns / 1ps

module i2cm_bus_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [i2cm_pkg::ReqDataW-1:0] req_tdata,  // tx_byte[7:0], ack_value, sda_in, zeros
   input  logic [i2cm_pkg::ReqUserW-1:0] req_tuser,  // cmd_valid, mode[2:0]
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [i2cm_pkg::RspDataW-1:0] rsp_tdata,  // scl, sda_release, busy_res, done_res,
                                                     // rx_byte[7:0], rx_ack, zeros
   output int                            failures,
   output int                            pending
);
   import i2cm_pkg::*;

   // predicted sequencer state
   cmd_type        cur_cmd;
   logic [4:0]     step_no;
   logic [7:0]     shifter;
   logic           busy_q;
   logic           scl_q;
   logic           sda_q;
   logic           ack_q;
   logic [7:0]     rx_q;

   i2cm_rsp_type   bus_levels_due[$];
   i2cm_rsp_type   due;
   i2cm_rsp_type   fresh;

   initial begin
      failures = 0;
      pending  = 0;
   end

   // one tick of the pin sequencer, giving the bus levels and flags that follow it
   task automatic advance_bus(input logic cmd_v, input logic [2:0] mode, input logic [7:0] tx,
                              input logic ack_v, input logic sda_v, output i2cm_rsp_type lv);
      logic       done;
      logic [4:0] last;
      int         ph;
      int         bi;
      done = 1'b0;
      // a command is only taken when idle and known
      if (!busy_q && cmd_v && mode <= CMD_RACK) begin
         cur_cmd = cmd_type'(mode);
         step_no = '0;
         busy_q  = 1'b1;
         if (mode == CMD_WRITE) shifter = tx;
         else if (mode == CMD_SACK) shifter = {7'b0, ack_v};
      end
      if (busy_q) begin
         case (cur_cmd)
            CMD_START: begin
               case (step_no)
                  5'd0: sda_q = 1'b1;
                  5'd1: scl_q = 1'b1;
                  5'd2: sda_q = 1'b0;
                  default: scl_q = 1'b0;
               endcase
            end
            CMD_STOP: begin
               case (step_no)
                  5'd0: sda_q = 1'b0;
                  5'd1: scl_q = 1'b1;
                  default: sda_q = 1'b1;
               endcase
            end
            CMD_WRITE: begin
               ph = step_no % 3;
               bi = step_no / 3;
               if (ph == 0) sda_q = shifter[7 - bi];
               else if (ph == 1) scl_q = 1'b1;
               else scl_q = 1'b0;
            end
            CMD_READ: begin
               if (step_no == 5'd0) begin
                  sda_q   = 1'b1;
                  shifter = '0;
               end else if (step_no[0]) begin
                  scl_q = 1'b1;
               end else begin
                  // sample on the tick after scl rose, msb first
                  shifter = {shifter[6:0], sda_v};
                  scl_q   = 1'b0;
               end
            end
            CMD_SACK: begin
               case (step_no)
                  5'd0: sda_q = shifter[0];
                  5'd1: scl_q = 1'b1;
                  default: scl_q = 1'b0;
               endcase
            end
            default: begin
               case (step_no)
                  5'd0: sda_q = 1'b1;
                  5'd1: scl_q = 1'b1;
                  default: begin
                     ack_q = sda_v;
                     scl_q = 1'b0;
                  end
               endcase
            end
         endcase
         step_no = step_no + 5'd1;
         case (cur_cmd)
            CMD_START: last = 5'd4;
            CMD_WRITE: last = 5'd24;
            CMD_READ:  last = 5'd17;
            default:   last = 5'd3;
         endcase
         if (step_no >= last) begin
            busy_q = 1'b0;
            done   = 1'b1;
            if (cur_cmd == CMD_READ) rx_q = shifter;
         end
      end
      lv = '{scl: scl_q, sda_release: sda_q, busy_res: busy_q, done_res: done,
             rx_byte: rx_q, rx_ack: ack_q};
   endtask

   task automatic check_field(input string name, input int expv, input int actv);
      if (expv != actv) begin
         $error("%s: expected %0d, actual %0d", name, expv, actv);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cur_cmd = CMD_START;
         step_no = '0;
         shifter = '0;
         busy_q  = 1'b0;
         scl_q   = 1'b1;
         sda_q   = 1'b1;
         ack_q   = 1'b0;
         rx_q    = '0;
         bus_levels_due.delete();
      end else begin
         // a result always leaves after its request, so compare before queueing
         if (rsp_tvalid && rsp_tready) begin
            if (bus_levels_due.size() == 0) begin
               $error("result beat %h with no expectation waiting", rsp_tdata);
               failures++;
            end else begin
               due = bus_levels_due.pop_front();
               check_field("scl", due.scl, rsp_tdata[0]);
               check_field("sda_release", due.sda_release, rsp_tdata[1]);
               check_field("busy_res", due.busy_res, rsp_tdata[2]);
               check_field("done_res", due.done_res, rsp_tdata[3]);
               check_field("rx_byte", due.rx_byte, rsp_tdata[11:4]);
               check_field("rx_ack", due.rx_ack, rsp_tdata[12]);
            end
         end
         if (req_tvalid && req_tready) begin
            advance_bus(req_tuser[0], req_tuser[3:1], req_tdata[7:0], req_tdata[8],
                        req_tdata[9], fresh);
            bus_levels_due.push_back(fresh);
         end
      end
      pending = bus_levels_due.size();
   end

endmodule

// ----- test/tb_i2c_master_bit_engine.sv -----
// top of the i2c master bit engine testbench: clock, reset, tick stimulus and the verdict
// depends on i2cm_pkg, the engine itself and i2cm_bus_checker
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine;
   import i2cm_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ReqDataW-1:0]   req_tdata  = '0;   // tx_byte[7:0], ack_value, sda_in, zeros
   logic [ReqUserW-1:0]   req_tuser  = '0;   // cmd_valid, mode[2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RspDataW-1:0]   rsp_tdata;         // scl, sda_release, busy_res, done_res,
                                             // rx_byte[7:0], rx_ack, zeros
   int                    failures;
   int                    pending;

   int                    send_idle_pct = 0;
   int                    stall_pct     = 0;
   int                    beats_sent    = 0;
   int                    mode_issued[8];
   int                    frames_run    = 0;

   // 8 ns period
   always #4 clock = ~clock;

   i2c_master_bit_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   i2cm_bus_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .pending    (pending)
   );

   // receiver back-pressure, redrawn every cycle at the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // one tick beat; entered and left just after a falling edge
   task automatic send_beat(input logic cv, input logic [2:0] m, input logic [7:0] tx,
                            input logic av, input logic sd);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {m, cv};
      req_tdata  <= {6'b0, sd, av, tx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      beats_sent++;
   endtask

   // offer a command, then tick through the rest of its sequence
   // sda_pick: 0 or 1 forces sda_in, anything higher draws it at random
   // busy_offer_pct: chance that a tick inside the sequence also offers a (to be ignored) command
   task automatic issue(input logic [2:0] mode, input logic [7:0] tx, input logic ack,
                        input int sda_pick, input int busy_offer_pct);
      int n;
      case (mode)
         CMD_START: n = 4;
         CMD_STOP:  n = 3;
         CMD_WRITE: n = 24;
         CMD_READ:  n = 17;
         CMD_SACK:  n = 3;
         CMD_RACK:  n = 3;
         default:   n = 1;   // unknown modes leave the engine idle
      endcase
      // occasional quiet ticks between commands, pins must hold
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 2))
            send_beat(1'b0, 3'($urandom_range(7)), 8'($urandom), 1'($urandom),
                      1'($urandom));
      end
      mode_issued[mode]++;
      send_beat(1'b1, mode, tx, ack, (sda_pick > 1) ? 1'($urandom) : 1'(sda_pick));
      repeat (n - 1)
         send_beat($urandom_range(99) < busy_offer_pct, 3'($urandom_range(7)), 8'($urandom),
                   1'($urandom), (sda_pick > 1) ? 1'($urandom) : 1'(sda_pick));
   endtask

   // a well-formed transfer: start, address, ack, some data bytes with acks, stop
   task automatic run_frame;
      issue(CMD_START, 8'($urandom), 1'($urandom), 2, 10);
      issue(CMD_WRITE, 8'($urandom), 1'($urandom), 2, 10);
      issue(CMD_RACK, 8'($urandom), 1'($urandom), 2, 10);
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(1)) begin
            issue(CMD_WRITE, 8'($urandom), 1'($urandom), 2, 10);
            issue(CMD_RACK, 8'($urandom), 1'($urandom), 2, 10);
         end else begin
            issue(CMD_READ, 8'($urandom), 1'($urandom), 2, 10);
            issue(CMD_SACK, 8'($urandom), 1'($urandom), 2, 10);
         end
      end
      issue(CMD_STOP, 8'($urandom), 1'($urandom), 2, 10);
      frames_run++;
   endtask

   // hold the sender off until every predicted result has been taken
   task automatic drain;
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int target;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every command, byte extremes, both ack levels, fixed sda on reads
      issue(CMD_START, 8'h00, 1'b0, 2, 0);
      issue(CMD_WRITE, 8'hFF, 1'b0, 2, 0);
      issue(CMD_RACK, 8'h00, 1'b0, 0, 0);
      issue(CMD_WRITE, 8'h00, 1'b1, 2, 0);
      issue(CMD_RACK, 8'hFF, 1'b1, 1, 0);
      issue(CMD_READ, 8'h00, 1'b0, 1, 0);
      issue(CMD_SACK, 8'hFF, 1'b0, 2, 0);
      issue(CMD_READ, 8'hFF, 1'b1, 0, 0);
      issue(CMD_SACK, 8'h00, 1'b1, 2, 0);
      // unknown modes are ignored
      issue(3'd6, 8'hA5, 1'b1, 2, 0);
      issue(3'd7, 8'h5A, 1'b0, 2, 0);
      // commands offered on every busy tick must all be dropped
      issue(CMD_WRITE, 8'h96, 1'b1, 2, 100);
      issue(CMD_STOP, 8'h00, 1'b0, 2, 100);

      // random part in four handshake mixes, draining between them
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 56; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 56; end
            default: begin send_idle_pct = 29; stall_pct = 29; end
         endcase
         target = beats_sent + 210;
         while (beats_sent < target) begin
            if ($urandom_range(4) == 0)
               // loose command, any mode, heavy offering while busy
               issue(3'($urandom_range(7)), 8'($urandom), 1'($urandom), 2, 40);
            else
               run_frame();
         end
         drain();
      end

      // wait for the tail, then idle on for anything stray
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("covered %0d tick beats, %0d full transfers, four stall and gap mixes",
               beats_sent, frames_run);
      $display("commands offered: start %0d stop %0d write %0d read %0d ack out %0d ack in %0d",
               mode_issued[CMD_START], mode_issued[CMD_STOP], mode_issued[CMD_WRITE],
               mode_issued[CMD_READ], mode_issued[CMD_SACK], mode_issued[CMD_RACK]);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- i2c_master_bit_engine.f -----
rtl/i2cm_pkg.sv
rtl/i2cm_step.sv
rtl/i2c_master_bit_engine.sv
test/i2cm_bus_checker.sv
test/tb_i2c_master_bit_engine.sv
